### sv/sati_pkg.sv
// Package for the six-axis trapezoid motion interpolator.
// Types, constants and state encoding; no dependencies.
`default_nettype none
package sati_pkg;
  localparam int JOINTS = 6;
  localparam int SPEED_MIN_DEF = 1;
  localparam int SPEED_MAX_DEF = 200;
  localparam int FRAC_DEF = 16;
  localparam int MS_PER_SEC = 1000;
  localparam int BIG_JOINT_SPEED = 140;
  localparam logic [7:0] START_SPEED_RST = 8'd40;
  localparam logic [7:0] HOME_ANGLE = 8'd90;
  localparam logic [7:0] HOME_GRIP = 8'd73;
  localparam logic [9:0] BIG_DELAY = 10'(MS_PER_SEC / BIG_JOINT_SPEED);

  // input word modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // divider slots: 0..5 joint increments, then ceiling and fast delays
  localparam logic [2:0] DIV_CEIL = 3'd6;
  localparam logic [2:0] DIV_FAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic [JOINTS-1:0][7:0] angle;
  } angles_t;

  typedef struct packed {
    logic start_load;
    logic start_tick;
    logic div_go;
    logic div_store;
    logic [2:0] div_sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

### sv/sati_if.sv
// Valid/ready channel interface carrying one word of payload type T.
// Depends on nothing.
`default_nettype none
interface sati_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/sati_ctrl.sv
// Controller: sequences a word through load division or tick and holds output.
// Depends on sati_pkg.
`default_nettype none
module sati_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_mode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire sati_pkg::stat_t stat,
  output sati_pkg::cmd_t       cmd
);
  import sati_pkg::*;
  state_t state, state_next;
  logic [2:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel <= '0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd.div_sel = sel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_TICK) begin
            cmd.start_tick = 1'b1;
            state_next = ST_OUT;
          end else begin
            cmd.start_load = 1'b1;
            if (stat.busy || stat.zero) state_next = ST_OUT;
            else begin
              sel_next = '0;
              state_next = ST_DIV;
            end
          end
        end
      end
      // start one division
      ST_DIV: begin
        cmd.div_go = 1'b1;
        state_next = ST_WAIT;
      end
      // store the quotient, then the next slot or the output
      ST_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (sel == DIV_FAST) state_next = ST_OUT;
          else begin
            sel_next = sel + 3'd1;
            state_next = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### sv/sati_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module sati_div #(parameter int W = 24) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] num,
  input  wire logic [9:0]   den,
  output logic [W-1:0]      quo,
  output logic              done
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q;
  logic [10:0]  r;
  logic [CW-1:0] cnt;
  logic [11:0]  trial;

  assign trial = {r, q[W-1]} - {2'b0, den};
  assign quo = q;

  // shift one numerator bit into the remainder per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else if (go) begin
      q <= num;
      r <= '0;
      cnt <= CW'(W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
      done <= (cnt == CW'(1));
      if (!trial[11]) begin
        r <= trial[10:0];
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= {r[9:0], q[W-1]};
        q <= {q[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### sv/sati_dp.sv
// Datapath: joint state, load setup through a shared divider, tick update.
// Depends on sati_pkg and sati_div.
`default_nettype none
module sati_dp #(
  parameter int SPEED_MIN = sati_pkg::SPEED_MIN_DEF,
  parameter int SPEED_MAX = sati_pkg::SPEED_MAX_DEF,
  parameter int FRAC = sati_pkg::FRAC_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sati_pkg::cmd_t   cmd,
  output sati_pkg::stat_t       stat,
  input  wire logic [7:0]       start_speed,
  input  wire logic [7:0]       speed,
  input  wire sati_pkg::angles_t targets,
  output sati_pkg::angles_t     angles,
  output logic [9:0]            delay_ms,
  output logic                  moving,
  output logic                  final_step
);
  import sati_pkg::*;
  localparam int AW = 8 + FRAC;
  localparam int IW = AW + 1;
  localparam int SW = $clog2(SPEED_MAX + 1);

  logic [7:0]    tgt [JOINTS];
  logic [AW-1:0] acc [JOINTS];
  logic [IW-1:0] inc [JOINTS];
  logic [8:0]    diff [JOINTS];
  logic [AW-1:0] nacc [JOINTS];
  logic [7:0]    steps, idx, turn;
  logic [9:0]    cur, flr, ceil;
  logic          decel;
  logic [SW-1:0] s, s0;
  logic [AW-1:0] dnum, dquo;
  logic [9:0]    dden;
  logic          ddone;
  logic          zero_move;
  logic [9:0]    dm1, dp1, nd;
  logic          dec_n, last;
  logic [9:0]    gap;
  logic [7:0]    mx;
  logic          big;

  function automatic logic [SW-1:0] clampw(input logic [7:0] v);
    if (32'(v) < SPEED_MIN) return SW'(SPEED_MIN);
    if (32'(v) > SPEED_MAX) return SW'(SPEED_MAX);
    return SW'(v);
  endfunction

  function automatic logic [7:0] mag9(input logic [8:0] d);
    return d[8] ? 8'(-d) : d[7:0];
  endfunction

  // status: busy move, load with no motion, divider finished
  always_comb begin
    zero_move = 1'b1;
    for (int j = 0; j < JOINTS; j++)
      if (targets.angle[j] != tgt[j]) zero_move = 1'b0;
    stat.busy = (steps != 8'd0);
    stat.zero = zero_move;
    stat.div_done = ddone;
  end

  // largest joint move and big-joint test on the latched differences
  always_comb begin
    mx = 8'd0;
    for (int j = 0; j < JOINTS; j++)
      if (mag9(diff[j]) > mx) mx = mag9(diff[j]);
    big = (11'd5 * 11'(mag9(diff[0])) > 11'd3 * 11'(mx)) ||
          (11'd5 * 11'(mag9(diff[1])) > 11'd3 * 11'(mx));
  end

  // divider operand select: 0..5 increments, then ceiling and fast delay
  always_comb begin
    dnum = AW'(MS_PER_SEC);
    dden = {2'b0, mx};
    case (cmd.div_sel)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5:
        dnum = {mag9(diff[cmd.div_sel]), FRAC'(0)};
      DIV_CEIL: begin
        dnum = AW'(MS_PER_SEC);
        dden = 10'((s0 < s) ? s0 : s);
      end
      default: begin
        dnum = AW'(MS_PER_SEC);
        dden = 10'(s);
      end
    endcase
  end

  sati_div #(.W(AW)) u_div (
    .clk(clk), .rst(rst), .go(cmd.div_go), .num(dnum), .den(dden),
    .quo(dquo), .done(ddone)
  );

  // tick arithmetic
  always_comb begin
    dec_n = decel | (idx == turn);
    dm1 = cur - 10'd1;
    dp1 = cur + 10'd1;
    nd = dec_n ? dp1 : dm1;
    if (nd < flr) nd = flr;
    if (nd > ceil) nd = ceil;
    last = (idx + 8'd1) >= steps;
    for (int j = 0; j < JOINTS; j++) nacc[j] = acc[j] + inc[j][AW-1:0];
  end

  // gap between the slow and fast delays, fast delay is the last quotient
  assign gap = ceil - dquo[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) begin
        tgt[j] <= (j == JOINTS - 1) ? HOME_GRIP : HOME_ANGLE;
        acc[j] <= {((j == JOINTS - 1) ? HOME_GRIP : HOME_ANGLE), FRAC'(0)};
        inc[j] <= '0;
        diff[j] <= '0;
      end
      steps <= '0; idx <= '0; turn <= '0;
      cur <= '0; flr <= '0; ceil <= '0; decel <= 1'b0;
      s <= '0; s0 <= '0;
      delay_ms <= '0; moving <= 1'b0; final_step <= 1'b0;
      angles <= '0;
    end else if (cmd.start_load) begin
      delay_ms <= '0;
      if (steps != 8'd0) begin
        // ignored while busy
        for (int j = 0; j < JOINTS; j++) angles.angle[j] <= acc[j][AW-1:FRAC];
        moving <= 1'b1; final_step <= 1'b0;
      end else if (zero_move) begin
        // zero-step load finishes at once
        for (int j = 0; j < JOINTS; j++) begin
          acc[j] <= {targets.angle[j], FRAC'(0)};
          angles.angle[j] <= targets.angle[j];
        end
        moving <= 1'b0; final_step <= 1'b1;
      end else begin
        for (int j = 0; j < JOINTS; j++) begin
          diff[j] <= {1'b0, targets.angle[j]} - {1'b0, tgt[j]};
          tgt[j] <= targets.angle[j];
        end
        s <= clampw(speed);
        s0 <= clampw(start_speed);
      end
    end else if (cmd.div_store) begin
      // collect quotients
      case (cmd.div_sel)
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5:
          inc[cmd.div_sel] <= diff[cmd.div_sel][8] ? -{1'b0, dquo} : {1'b0, dquo};
        DIV_CEIL: ceil <= dquo[9:0];
        default: begin
          flr <= (big && BIG_DELAY > dquo[9:0]) ? BIG_DELAY : dquo[9:0];
          cur <= ceil;
          turn <= ({3'b0, mx} > {gap, 1'b0}) ? (mx - gap[7:0]) : (mx >> 1);
          steps <= mx; idx <= '0; decel <= 1'b0;
          for (int j = 0; j < JOINTS; j++) angles.angle[j] <= acc[j][AW-1:FRAC];
          moving <= 1'b1; final_step <= 1'b0; delay_ms <= '0;
        end
      endcase
    end else if (cmd.start_tick) begin
      if (steps == 8'd0) begin
        for (int j = 0; j < JOINTS; j++) angles.angle[j] <= tgt[j];
        delay_ms <= '0; moving <= 1'b0; final_step <= 1'b0;
      end else begin
        delay_ms <= cur;
        cur <= nd;
        decel <= dec_n;
        if (last) begin
          steps <= '0; idx <= '0;
          for (int j = 0; j < JOINTS; j++) begin
            acc[j] <= {tgt[j], FRAC'(0)};
            angles.angle[j] <= tgt[j];
          end
          moving <= 1'b0; final_step <= 1'b1;
        end else begin
          idx <= idx + 8'd1;
          for (int j = 0; j < JOINTS; j++) begin
            acc[j] <= nacc[j];
            angles.angle[j] <= nacc[j][AW-1:FRAC];
          end
          moving <= 1'b1; final_step <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

### sv/six_axis_trapezoid_motion_interpolator_unit.sv
// Six-axis trapezoid motion interpolator, top level.
// Channels: in (mode, speed, six targets) and out (six angles, delay, flags),
//   valid/ready; start_speed register written by cfg_we/cfg_data.
// Every input word yields exactly one output word, held until taken.
// Tick, busy load and zero-step load: output valid in the cycle after accept.
// Load from idle runs eight serial divisions (six increments, two delays)
// through one shared divider; each is a start, a shift of all 8+FRACTION_BITS
// numerator bits and a store, and the output is valid after the last one.
// Input is accepted only in idle, after the output word is taken,
// so a new word is never accepted while a previous output word is pending.
// Reset puts all joints at home (90, gripper 73), idle, start_speed 40.
// A stalled receiver holds the output word and blocks new input.
// Depends on sati_pkg, sati_ctrl, sati_dp, sati_div.
`default_nettype none
module six_axis_trapezoid_motion_interpolator_unit #(
  parameter int SPEED_MIN = sati_pkg::SPEED_MIN_DEF,
  parameter int SPEED_MAX = sati_pkg::SPEED_MAX_DEF,
  parameter int FRACTION_BITS = sati_pkg::FRAC_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_we,
  input wire logic [7:0] cfg_data,
  input wire logic       in_valid,
  output logic           in_ready,
  input wire logic       mode,
  input wire logic [7:0] speed,
  input wire logic [7:0] base_target,
  input wire logic [7:0] shoulder_target,
  input wire logic [7:0] elbow_target,
  input wire logic [7:0] wrist_rotation_target,
  input wire logic [7:0] wrist_target,
  input wire logic [7:0] gripper_target,
  output logic           out_valid,
  input wire logic       out_ready,
  output logic [7:0]     base_angle,
  output logic [7:0]     shoulder_angle,
  output logic [7:0]     elbow_angle,
  output logic [7:0]     wrist_rotation_angle,
  output logic [7:0]     wrist_angle,
  output logic [7:0]     gripper_angle,
  output logic [9:0]     delay_ms,
  output logic           moving,
  output logic           final_step
);
  import sati_pkg::*;
  logic [7:0] start_speed;
  cmd_t  cmd;
  stat_t stat;
  angles_t tg, an;

  always_ff @(posedge clk) begin
    if (rst) start_speed <= START_SPEED_RST;
    else if (cfg_we) start_speed <= cfg_data;
  end

  assign tg.angle[0] = base_target;
  assign tg.angle[1] = shoulder_target;
  assign tg.angle[2] = elbow_target;
  assign tg.angle[3] = wrist_rotation_target;
  assign tg.angle[4] = wrist_target;
  assign tg.angle[5] = gripper_target;
  assign base_angle = an.angle[0];
  assign shoulder_angle = an.angle[1];
  assign elbow_angle = an.angle[2];
  assign wrist_rotation_angle = an.angle[3];
  assign wrist_angle = an.angle[4];
  assign gripper_angle = an.angle[5];

  sati_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_mode(mode),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  sati_dp #(.SPEED_MIN(SPEED_MIN), .SPEED_MAX(SPEED_MAX), .FRAC(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .start_speed(start_speed),
    .speed(speed), .targets(tg), .angles(an), .delay_ms(delay_ms),
    .moving(moving), .final_step(final_step)
  );
endmodule
`default_nettype wire

### sv/sati_chk.sv
// Port-level checker for the interpolator, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module sati_chk (
  input wire logic clk, rst, in_valid, in_ready, out_valid, out_ready,
  input wire logic moving, final_step
);
  // one word in flight: no accept while a result is pending
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // flags never both set while the output is valid
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(moving && final_step)) else $error("moving and final");
  // output held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
endmodule
bind six_axis_trapezoid_motion_interpolator_unit sati_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .moving(moving),
  .final_step(final_step)
);
`default_nettype wire

### tb/tb_six_axis_trapezoid_motion_interpolator_unit.sv
// Testbench for the six-axis trapezoid motion interpolator: directed and random
// load/tick words checked against a behavioral motion predictor.
// Depends on sati_pkg, sati_if and the six_axis_trapezoid_motion_interpolator_unit RTL.
module tb_six_axis_trapezoid_motion_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sati_pkg::*;

  localparam int FRAC = 16;
  localparam int SPD_LO = 1;
  localparam int SPD_HI = 200;
  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    logic            mode;
    logic [7:0]      speed;
    logic [5:0][7:0] tgt;   // index 0 is base, 5 is gripper
  } cmd_word_t;

  typedef struct packed {
    logic [5:0][7:0] ang;
    logic [9:0]      delay;
    logic            moving;
    logic            fin;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  bit no_idle = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  string angle_names [6] = '{"base_angle", "shoulder_angle", "elbow_angle",
                             "wrist_rotation_angle", "wrist_angle", "gripper_angle"};

  always #6 clk = ~clk;

  sati_if #(cmd_word_t)  cmd_ch (clk);
  sati_if #(pose_word_t) pose_ch (clk);

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    pose_ch.ready = 1'b0;
  end

  six_axis_trapezoid_motion_interpolator_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready),
    .mode(cmd_ch.data.mode), .speed(cmd_ch.data.speed),
    .base_target(cmd_ch.data.tgt[0]), .shoulder_target(cmd_ch.data.tgt[1]),
    .elbow_target(cmd_ch.data.tgt[2]), .wrist_rotation_target(cmd_ch.data.tgt[3]),
    .wrist_target(cmd_ch.data.tgt[4]), .gripper_target(cmd_ch.data.tgt[5]),
    .out_valid(pose_ch.valid), .out_ready(pose_ch.ready),
    .base_angle(pose_ch.data.ang[0]), .shoulder_angle(pose_ch.data.ang[1]),
    .elbow_angle(pose_ch.data.ang[2]), .wrist_rotation_angle(pose_ch.data.ang[3]),
    .wrist_angle(pose_ch.data.ang[4]), .gripper_angle(pose_ch.data.ang[5]),
    .delay_ms(pose_ch.data.delay), .moving(pose_ch.data.moving),
    .final_step(pose_ch.data.fin)
  );

  // ---------------- motion predictor state ----------------
  logic [7:0]              pm_start_speed = START_SPEED_RST;
  logic [5:0][7:0]         pm_target;
  logic [23:0]             pm_acc [6];
  logic signed [24:0]      pm_inc [6];
  int pm_index, pm_total, pm_turn, pm_delay, pm_floor, pm_ceil;
  bit pm_decel;
  pose_word_t pose_queue[$];

  function automatic int clamp_speed(int v);
    if (v < SPD_LO) return SPD_LO;
    if (v > SPD_HI) return SPD_HI;
    return v;
  endfunction

  task automatic park_joints();
    for (int j = 0; j < 6; j++) pm_acc[j] = {pm_target[j], 16'h0};
  endtask

  function automatic pose_word_t pose_of(bit exact, int d, bit mv, bit fin);
    pose_word_t r;
    for (int j = 0; j < 6; j++) r.ang[j] = exact ? pm_target[j] : pm_acc[j][23:16];
    r.delay = 10'(d);
    r.moving = mv;
    r.fin = fin;
    return r;
  endfunction

  task automatic predictor_reset();
    pm_start_speed = START_SPEED_RST;
    for (int j = 0; j < 6; j++) begin
      pm_target[j] = (j == 5) ? HOME_GRIP : HOME_ANGLE;
      pm_inc[j] = '0;
    end
    park_joints();
    pm_index = 0; pm_total = 0; pm_turn = 0;
    pm_delay = 0; pm_floor = 0; pm_ceil = 0; pm_decel = 0;
  endtask

  task automatic predict_pose(cmd_word_t w, output pose_word_t r);
    int diff [6];
    int steps, s, s0, fast, gap, mb, ms, d, nxt;
    longint mag, q;
    steps = 0;
    if (w.mode == MODE_LOAD) begin
      // loads are ignored while a move is running
      if (pm_total != 0) begin
        r = pose_of(0, 0, 1, 0);
        return;
      end
      for (int j = 0; j < 6; j++) begin
        diff[j] = int'(w.tgt[j]) - int'(pm_target[j]);
        if ((diff[j] < 0 ? -diff[j] : diff[j]) > steps) steps = diff[j] < 0 ? -diff[j] : diff[j];
      end
      pm_target = w.tgt;
      if (steps == 0) begin
        park_joints();
        r = pose_of(1, 0, 0, 1);
        return;
      end
      s = clamp_speed(w.speed);
      s0 = clamp_speed(pm_start_speed);
      pm_ceil = 1000 / (s0 < s ? s0 : s);
      fast = 1000 / s;
      gap = pm_ceil - fast;
      pm_floor = fast;
      mb = diff[0] < 0 ? -diff[0] : diff[0];
      ms = diff[1] < 0 ? -diff[1] : diff[1];
      // big joints moving far get a slower floor
      if ((5 * mb > 3 * steps || 5 * ms > 3 * steps) && int'(BIG_DELAY) > pm_floor)
        pm_floor = int'(BIG_DELAY);
      pm_turn = (steps > 2 * gap) ? steps - gap : steps / 2;
      for (int j = 0; j < 6; j++) begin
        mag = diff[j] < 0 ? -diff[j] : diff[j];
        q = (mag << FRAC) / steps;
        pm_inc[j] = diff[j] < 0 ? 25'(-q) : 25'(q);
      end
      pm_total = steps;
      pm_index = 0;
      pm_delay = pm_ceil;
      pm_decel = 0;
      r = pose_of(0, 0, 1, 0);
    end else begin
      if (pm_total == 0) begin
        r = pose_of(1, 0, 0, 0);
        return;
      end
      for (int j = 0; j < 6; j++) pm_acc[j] = pm_acc[j] + pm_inc[j][23:0];
      d = pm_delay;
      if (pm_index == pm_turn) pm_decel = 1;
      nxt = pm_decel ? d + 1 : d - 1;
      if (nxt < pm_floor) nxt = pm_floor;
      if (nxt > pm_ceil) nxt = pm_ceil;
      pm_delay = nxt;
      pm_index++;
      if (pm_index >= pm_total) begin
        pm_total = 0;
        pm_index = 0;
        park_joints();
        r = pose_of(1, d, 0, 1);
      end else begin
        r = pose_of(0, d, 1, 0);
      end
    end
  endtask

  // ---------------- receiver side ----------------
  always @(posedge clk) begin
    pose_ch.ready <= no_idle || ($urandom_range(99) >= 23);
  end

  // compare each taken pose word with the oldest prediction
  always @(posedge clk) begin
    pose_word_t e, a;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      a = pose_ch.data;
      if (pose_queue.size() == 0) begin
        $error("unexpected pose word %h", a);
        errors++;
      end else begin
        e = pose_queue.pop_front();
        for (int j = 0; j < 6; j++)
          if (a.ang[j] !== e.ang[j]) begin
            $error("%s: expected %0d, got %0d", angle_names[j], e.ang[j], a.ang[j]);
            errors++;
          end
        if (a.delay !== e.delay) begin
          $error("delay_ms: expected %0d, got %0d", e.delay, a.delay);
          errors++;
        end
        if (a.moving !== e.moving) begin
          $error("moving: expected %0d, got %0d", e.moving, a.moving);
          errors++;
        end
        if (a.fin !== e.fin) begin
          $error("final_step: expected %0d, got %0d", e.fin, a.fin);
          errors++;
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- sender side ----------------
  task automatic send_word(cmd_word_t w);
    pose_word_t r;
    if (!no_idle && $urandom_range(99) < 23) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    predict_pose(w, r);
    pose_queue.push_back(r);
    words_sent++;
  endtask

  // sender holds off until every expected word is back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_start_speed(logic [7:0] v);
    drain();
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pm_start_speed = v;
  endtask

  function automatic cmd_word_t load_word(logic [7:0] spd, logic [5:0][7:0] t);
    cmd_word_t w;
    w.mode = MODE_LOAD;
    w.speed = spd;
    w.tgt = t;
    return w;
  endfunction

  function automatic cmd_word_t tick_word();
    cmd_word_t w;
    w.mode = MODE_TICK;
    w.speed = 8'($urandom);
    for (int j = 0; j < 6; j++) w.tgt[j] = 8'($urandom);
    return w;
  endfunction

  // load a move and tick it through to its last step
  task automatic run_move(logic [7:0] spd, logic [5:0][7:0] t);
    send_word(load_word(spd, t));
    while (pm_total != 0) send_word(tick_word());
  endtask

  // ---------------- tests ----------------
  task automatic test_idle_and_zero_moves();
    logic [5:0][7:0] t;
    send_word(tick_word());
    t = pm_target;
    send_word(load_word(8'd100, t));       // zero-step load
    t[0] = 8'd91;
    run_move(8'd0, t);                       // one-step move, speed clamped up
    send_word(tick_word());
  endtask

  task automatic test_extremes();
    logic [5:0][7:0] t;
    for (int j = 0; j < 6; j++) t[j] = 8'd0;
    run_move(8'd255, t);                     // speed clamped down
    for (int j = 0; j < 6; j++) t[j] = 8'd255;
    send_word(load_word(8'd200, t));
    send_word(tick_word());
    send_word(load_word(8'd10, t));          // ignored while busy
    while (pm_total != 0) send_word(tick_word());
    for (int j = 0; j < 6; j++) t[j] = 8'd180;
    t[1] = 8'd0;
    run_move(8'd7, t);
  endtask

  task automatic test_profile_corners();
    logic [5:0][7:0] t;
    write_start_speed(8'd0);                 // slowest edge speed: 1000 ms ceiling
    t = pm_target;
    t[2] = t[2] - 8'd4;
    run_move(8'd1, t);
    t[3] = t[3] - 8'd30;
    run_move(8'd150, t);
    write_start_speed(8'd255);               // floor above ceiling case
    t = pm_target;
    t[0] = t[0] + 8'd20;
    run_move(8'd200, t);
    write_start_speed(8'd200);
    t = pm_target;
    t[4] = t[4] - 8'd40;
    run_move(8'd120, t);
    write_start_speed(8'd1);
    t = pm_target;
    t[5] = t[5] + 8'd3;
    t[1] = t[1] - 8'd3;
    run_move(8'd50, t);
    write_start_speed(START_SPEED_RST);
  endtask

  task automatic test_random();
    logic [5:0][7:0] t;
    int pick, span, phase;
    phase = 0;
    while (words_sent < 1500) begin
      if (words_sent >= 200 * (phase + 1)) begin
        phase++;
        no_idle = (phase == 3);
        if (phase % 2 == 0) write_start_speed(8'($urandom));
        else drain();                        // sender holds until all poses are back
      end
      pick = $urandom_range(99);
      if (pick < 85) begin
        span = ($urandom_range(99) < 8) ? 255 : $urandom_range(1, 24);
        for (int j = 0; j < 6; j++) begin
          if (span == 255) t[j] = 8'($urandom);
          else t[j] = 8'(int'(pm_target[j]) + $urandom_range(0, 2 * span) - span);
        end
        send_word(load_word(8'($urandom), t));
        while (pm_total != 0) begin
          if ($urandom_range(99) < 5) send_word(load_word(8'($urandom), t));
          else send_word(tick_word());
        end
      end else if (pick < 93) begin
        send_word(tick_word());
      end else begin
        t = pm_target;
        send_word(load_word(8'($urandom), t));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    predictor_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_zero_moves();
    test_extremes();
    test_profile_corners();
    test_random();
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
